@@ rtl/cia_pkg.sv @@
package cia_pkg;

    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_CORDIC_STEPS = 18;
    localparam int GUARD_BITS       = 4;
    localparam int TABLE_LEN        = 30;

    // Angles in radians, 30 fractional bits.
    localparam logic signed [35:0] ANG_PI      = 36'sd3373259426;
    localparam logic signed [35:0] ANG_HALF_PI = 36'sd1686629713;
    localparam logic signed [35:0] ANG_TWO_PI  = 36'sd6746518852;
    localparam logic [29:0]        INV_GAIN    = 30'd652032874;

    localparam logic [1:0] MODE_ADD = 2'd0;
    localparam logic [1:0] MODE_PAR = 2'd1;
    localparam logic [1:0] MODE_MUL = 2'd2;
    localparam logic [1:0] MODE_DIV = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_DIVZ = 2'd1;
    localparam logic [1:0] ST_OVF  = 2'd2;

    function automatic logic signed [35:0] atan_q30(input logic [4:0] i);
        logic signed [35:0] r;
        case (i)
            5'd0:    r = 36'sd843314856;
            5'd1:    r = 36'sd497837829;
            5'd2:    r = 36'sd263043836;
            5'd3:    r = 36'sd133525158;
            5'd4:    r = 36'sd67021686;
            5'd5:    r = 36'sd33543515;
            5'd6:    r = 36'sd16775850;
            5'd7:    r = 36'sd8388437;
            5'd8:    r = 36'sd4194282;
            5'd9:    r = 36'sd2097149;
            5'd10:   r = 36'sd1048575;
            5'd11:   r = 36'sd524287;
            5'd12:   r = 36'sd262143;
            5'd13:   r = 36'sd131071;
            5'd14:   r = 36'sd65535;
            5'd15:   r = 36'sd32767;
            5'd16:   r = 36'sd16383;
            5'd17:   r = 36'sd8191;
            5'd18:   r = 36'sd4095;
            5'd19:   r = 36'sd2047;
            5'd20:   r = 36'sd1023;
            5'd21:   r = 36'sd511;
            5'd22:   r = 36'sd255;
            5'd23:   r = 36'sd127;
            5'd24:   r = 36'sd63;
            5'd25:   r = 36'sd31;
            5'd26:   r = 36'sd15;
            5'd27:   r = 36'sd8;
            5'd28:   r = 36'sd4;
            5'd29:   r = 36'sd2;
            default: r = 36'sd0;
        endcase
        return r;
    endfunction

    // Phase sums and differences stay within (-2*pi, 2*pi], so one correction each way is enough.
    function automatic logic signed [35:0] wrap_ang(input logic signed [37:0] a);
        logic signed [37:0] t;
        t = a;
        if (t > 38'(ANG_PI))
        begin
            t = t - 38'(ANG_TWO_PI);
        end
        else if (t <= -38'(ANG_PI))
        begin
            t = t + 38'(ANG_TWO_PI);
        end
        return t[35:0];
    endfunction

    typedef struct packed {
        logic [1:0]         mode;
    } side_t;

endpackage

@@ rtl/cia_vec_stage.sv @@
module cia_vec_stage #(
    parameter int SHIFT = 0
) (
    input  logic signed [39:0] x_in,
    input  logic signed [39:0] y_in,
    input  logic signed [35:0] z_in,
    input  logic               rot,
    output logic signed [39:0] x_out,
    output logic signed [39:0] y_out,
    output logic signed [35:0] z_out
);
    import cia_pkg::*;

    logic signed [39:0] dx;
    logic signed [39:0] dy;
    logic               up;

    assign dx = y_in >>> SHIFT;
    assign dy = x_in >>> SHIFT;
    assign up = rot ? (z_in >= 36'sd0) : (y_in <= 40'sd0);

    always_comb
    begin
        if (up)
        begin
            x_out = x_in - dx;
            y_out = y_in + dy;
            z_out = z_in - atan_q30(5'(SHIFT));
        end
        else
        begin
            x_out = x_in + dx;
            y_out = y_in - dy;
            z_out = z_in + atan_q30(5'(SHIFT));
        end
    end

endmodule

@@ rtl/complex_impedance_alu_core.sv @@
// Channel | Dir | tdata fields, lowest bit first                     | tuser
// s_axis  | in  | a_re[31:0] a_im[63:32] b_re[95:64] b_im[127:96]     | mode[1:0]
// m_axis  | out | re[31:0] im[63:32] mag[94:64] phase[113:95], pad 0 | status[1:0]
// One pair is taken every cycle while the output register can take data.
// The pipeline length is set by the two unrolled CORDIC chains and the divider.
// Every stage advances only when the output register can take data, so a stall
// freezes the whole pipeline and nothing is lost or repeated.
// Reset clears only the valid bits.
module complex_impedance_alu_core #(
    parameter int FRAC_BITS    = cia_pkg::DEF_FRAC_BITS,
    parameter int CORDIC_STEPS = cia_pkg::DEF_CORDIC_STEPS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
    input  logic [1:0]   s_axis_tuser,  // mode
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [119:0] m_axis_tdata,  // res_re, res_im, res_mag, res_phase
    output logic [1:0]   m_axis_tuser   // status
);
    import cia_pkg::*;

    localparam int NV = CORDIC_STEPS;
    localparam int DL = 67;

    logic adv;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 0: operands and sums.
    logic               v0_reg;
    side_t              sd0_reg;
    logic signed [33:0] px0_reg [3];
    logic signed [33:0] py0_reg [3];
    logic signed [31:0] ar, ai, br, bi;
    assign ar = s_axis_tdata[31:0];
    assign ai = s_axis_tdata[63:32];
    assign br = s_axis_tdata[95:64];
    assign bi = s_axis_tdata[127:96];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
        end
        else if (adv)
        begin
            v0_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            px0_reg[0] <= 34'(ar);
            py0_reg[0] <= 34'(ai);
            px0_reg[1] <= 34'(br);
            py0_reg[1] <= 34'(bi);
            px0_reg[2] <= 34'(ar) + 34'(br);
            py0_reg[2] <= 34'(ai) + 34'(bi);
            sd0_reg.mode   <= s_axis_tuser;
        end
    end

    // Stage 1: prerotation into the right half plane, axis cases flagged.
    logic signed [39:0] vx_reg [3][NV+1];
    logic signed [39:0] vy_reg [3][NV+1];
    logic signed [35:0] vz_reg [3][NV+1];
    logic               ax_reg [3][NV+1];
    logic [33:0]        axm_reg [3][NV+1];
    logic signed [35:0] axa_reg [3][NV+1];
    logic               vv_reg [NV+1];
    logic [1:0]         vm_reg [NV+1];
    logic signed [33:0] sr_reg [NV+1];
    logic signed [33:0] si_reg [NV+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= NV; i++)
            begin
                vv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vv_reg[0] <= v0_reg;
            for (int i = 1; i <= NV; i++)
            begin
                vv_reg[i] <= vv_reg[i-1];
            end
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_vec
        logic signed [39:0] gx, gy;
        assign gx = 40'(px0_reg[k]) <<< GUARD_BITS;
        assign gy = 40'(py0_reg[k]) <<< GUARD_BITS;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                ax_reg[k][0] <= (py0_reg[k] == 34'sd0) || (px0_reg[k] == 34'sd0);
                if (py0_reg[k] == 34'sd0)
                begin
                    axm_reg[k][0] <= px0_reg[k][33] ? 34'(-px0_reg[k]) : 34'(px0_reg[k]);
                    axa_reg[k][0] <= px0_reg[k][33] ? ANG_PI : 36'sd0;
                end
                else
                begin
                    axm_reg[k][0] <= py0_reg[k][33] ? 34'(-py0_reg[k]) : 34'(py0_reg[k]);
                    axa_reg[k][0] <= py0_reg[k][33] ? -ANG_HALF_PI : ANG_HALF_PI;
                end
                if (gx < 0 && gy > 0)
                begin
                    vx_reg[k][0] <= gy;
                    vy_reg[k][0] <= -gx;
                    vz_reg[k][0] <= ANG_HALF_PI;
                end
                else if (gx < 0)
                begin
                    vx_reg[k][0] <= -gy;
                    vy_reg[k][0] <= gx;
                    vz_reg[k][0] <= -ANG_HALF_PI;
                end
                else
                begin
                    vx_reg[k][0] <= gx;
                    vy_reg[k][0] <= gy;
                    vz_reg[k][0] <= 36'sd0;
                end
            end
        end
        for (genvar i = 0; i < NV; i++)
        begin : g_st
            logic signed [39:0] nx, ny;
            logic signed [35:0] nz;
            cia_vec_stage #(.SHIFT(i)) u_st (
                .x_in  (vx_reg[k][i]),
                .y_in  (vy_reg[k][i]),
                .z_in  (vz_reg[k][i]),
                .rot   (1'b0),
                .x_out (nx),
                .y_out (ny),
                .z_out (nz)
            );
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    vx_reg[k][i+1]  <= nx;
                    vy_reg[k][i+1]  <= ny;
                    vz_reg[k][i+1]  <= nz;
                    ax_reg[k][i+1]  <= ax_reg[k][i];
                    axm_reg[k][i+1] <= axm_reg[k][i];
                    axa_reg[k][i+1] <= axa_reg[k][i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vm_reg[0] <= sd0_reg.mode;
            sr_reg[0] <= (sd0_reg.mode == MODE_ADD) ? px0_reg[2] : 34'sd0;
            si_reg[0] <= (sd0_reg.mode == MODE_ADD) ? py0_reg[2] : 34'sd0;
            for (int i = 1; i <= NV; i++)
            begin
                vm_reg[i] <= vm_reg[i-1];
                sr_reg[i] <= sr_reg[i-1];
                si_reg[i] <= si_reg[i-1];
            end
        end
    end

    // Gain compensation: split multiplies, then combine.
    logic        gv_reg [3];
    logic [1:0]  gm_reg [3];
    logic signed [33:0] gsr_reg [3];
    logic signed [33:0] gsi_reg [3];
    logic [39:0] gh_reg [3];
    logic [59:0] gl_reg [3];
    logic [49:0] gp_reg [3];
    logic        gax_reg [3];
    logic [33:0] gaxm_reg [3];
    logic        gax2_reg [3];
    logic [33:0] gaxm2_reg [3];
    logic signed [35:0] gz_reg [3];
    logic signed [35:0] gz2_reg [3];
    logic [33:0] mag_reg [3];
    logic signed [35:0] ang_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gv_reg[0] <= 1'b0;
            gv_reg[1] <= 1'b0;
            gv_reg[2] <= 1'b0;
        end
        else if (adv)
        begin
            gv_reg[0] <= vv_reg[NV];
            gv_reg[1] <= gv_reg[0];
            gv_reg[2] <= gv_reg[1];
        end
    end

    for (genvar k = 0; k < 3; k++)
    begin : g_gain
        logic [39:0] xc;
        assign xc = vx_reg[k][NV][39] ? 40'd0 : vx_reg[k][NV];
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                gh_reg[k] <= 40'(xc[39:30]) * 40'(INV_GAIN);
                gl_reg[k] <= 60'(xc[29:0]) * 60'(INV_GAIN);
                gax_reg[k] <= ax_reg[k][NV];
                gaxm_reg[k] <= axm_reg[k][NV];
                gz_reg[k] <= ax_reg[k][NV] ? axa_reg[k][NV] :
                             wrap_ang(38'(vz_reg[k][NV]));
                gp_reg[k] <= 50'(gh_reg[k]) + 50'(gl_reg[k] >> 30)
                             + 50'(1 << (GUARD_BITS - 1));
                gax2_reg[k] <= gax_reg[k];
                gaxm2_reg[k] <= gaxm_reg[k];
                gz2_reg[k] <= gz_reg[k];
                mag_reg[k] <= gax2_reg[k] ? gaxm2_reg[k] : 34'(gp_reg[k] >> GUARD_BITS);
                ang_reg[k] <= gz2_reg[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gm_reg[0] <= vm_reg[NV];
            gsr_reg[0] <= sr_reg[NV];
            gsi_reg[0] <= si_reg[NV];
            for (int i = 1; i < 3; i++)
            begin
                gm_reg[i] <= gm_reg[i-1];
                gsr_reg[i] <= gsr_reg[i-1];
                gsi_reg[i] <= gsi_reg[i-1];
            end
        end
    end

    // Combine: numerator, denominator, phase.
    logic        cv_reg;
    logic [1:0]  cm_reg;
    logic [66:0] num_reg;
    logic [33:0] den_reg;
    logic signed [35:0] cph_reg;
    logic signed [33:0] csr_reg, csi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cv_reg <= 1'b0;
        end
        else if (adv)
        begin
            cv_reg <= gv_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cm_reg <= gm_reg[2];
            csr_reg <= gsr_reg[2];
            csi_reg <= gsi_reg[2];
            case (gm_reg[2])
                MODE_ADD:
                begin
                    num_reg <= 67'(mag_reg[2]);
                    den_reg <= 34'd1;
                    cph_reg <= ang_reg[2];
                end
                MODE_PAR:
                begin
                    num_reg <= 67'(mag_reg[0]) * 67'(mag_reg[1]) + 67'(mag_reg[2] >> 1);
                    den_reg <= mag_reg[2];
                    cph_reg <= wrap_ang(38'(wrap_ang(38'(ang_reg[0]) + 38'(ang_reg[1])))
                                        - 38'(ang_reg[2]));
                end
                MODE_MUL:
                begin
                    num_reg <= (67'(mag_reg[0]) * 67'(mag_reg[1])
                                + 67'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                    den_reg <= 34'd1;
                    cph_reg <= wrap_ang(38'(ang_reg[0]) + 38'(ang_reg[1]));
                end
                default:
                begin
                    num_reg <= (67'(mag_reg[0]) << FRAC_BITS) + 67'(mag_reg[1] >> 1);
                    den_reg <= mag_reg[1];
                    cph_reg <= wrap_ang(38'(ang_reg[0]) - 38'(ang_reg[1]));
                end
            endcase
        end
    end

    // Pipelined restoring divider, one quotient bit per stage.
    logic        dv_reg [DL+1];
    logic [1:0]  dm_reg [DL+1];
    logic [66:0] dq_reg [DL+1];
    logic [67:0] drm_reg [DL+1];
    logic [33:0] dd_reg [DL+1];
    logic signed [35:0] dph_reg [DL+1];
    logic signed [33:0] dsr_reg [DL+1];
    logic signed [33:0] dsi_reg [DL+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DL; i++)
            begin
                dv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            dv_reg[0] <= cv_reg;
            for (int i = 1; i <= DL; i++)
            begin
                dv_reg[i] <= dv_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dm_reg[0]  <= cm_reg;
            dq_reg[0]  <= num_reg;
            drm_reg[0] <= 68'd0;
            dd_reg[0]  <= den_reg;
            dph_reg[0] <= cph_reg;
            dsr_reg[0] <= csr_reg;
            dsi_reg[0] <= csi_reg;
        end
    end

    for (genvar i = 0; i < DL; i++)
    begin : g_div
        logic [67:0] rs, rt;
        assign rs = {drm_reg[i][66:0], dq_reg[i][66]};
        assign rt = rs - 68'(dd_reg[i]);
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dm_reg[i+1]  <= dm_reg[i];
                dd_reg[i+1]  <= dd_reg[i];
                dph_reg[i+1] <= dph_reg[i];
                dsr_reg[i+1] <= dsr_reg[i];
                dsi_reg[i+1] <= dsi_reg[i];
                if (dd_reg[i] != 34'd0 && !rt[67])
                begin
                    drm_reg[i+1] <= rt;
                    dq_reg[i+1]  <= {dq_reg[i][65:0], 1'b1};
                end
                else
                begin
                    drm_reg[i+1] <= rs;
                    dq_reg[i+1]  <= {dq_reg[i][65:0], 1'b0};
                end
            end
        end
    end

    // Quotient register.
    logic        ev_reg;
    logic [1:0]  em_reg;
    logic [66:0] em_q_reg;
    logic        ez_reg;
    logic signed [35:0] eph_reg;
    logic signed [33:0] esr_reg, esi_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ev_reg <= 1'b0;
        end
        else if (adv)
        begin
            ev_reg <= dv_reg[DL];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            em_reg  <= dm_reg[DL];
            ez_reg  <= (dd_reg[DL] == 34'd0);
            em_q_reg <= dq_reg[DL];
            eph_reg <= dph_reg[DL];
            esr_reg <= dsr_reg[DL];
            esi_reg <= dsi_reg[DL];
        end
    end

    // Rotating CORDIC front end: range shift and gain compensation.
    logic        rv_reg [NV+3];
    logic [1:0]  rm_reg [NV+3];
    logic        rz_reg [NV+3];
    logic [66:0] rmag_reg [NV+3];
    logic [5:0]  rs_reg [NV+3];
    logic signed [35:0] rph_reg [NV+3];
    logic signed [33:0] rsr_reg [NV+3];
    logic signed [33:0] rsi_reg [NV+3];
    logic [44:0] rsh_reg;
    logic [44:0] rgh_reg;
    logic [59:0] rgl_reg;
    logic signed [49:0] rx_reg [NV+1];
    logic signed [49:0] ry_reg [NV+1];
    logic signed [35:0] rzz_reg [NV+1];

    function automatic logic [5:0] shift_of(input logic [66:0] m);
        logic [5:0] s;
        s = 6'd0;
        for (int j = 66; j >= 40; j--)
        begin
            if (m[j] && s == 6'd0)
            begin
                s = 6'(j - 39);
            end
        end
        return s;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NV + 3; i++)
            begin
                rv_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            rv_reg[0] <= ev_reg;
            for (int i = 1; i < NV + 3; i++)
            begin
                rv_reg[i] <= rv_reg[i-1];
            end
        end
    end

    logic [66:0] mq;
    assign mq = em_q_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rm_reg[0]   <= em_reg;
            rz_reg[0]   <= ez_reg;
            rmag_reg[0] <= mq;
            rs_reg[0]   <= shift_of(mq);
            rph_reg[0]  <= (mq == 67'd0) ? 36'sd0 : eph_reg;
            rsr_reg[0]  <= esr_reg;
            rsi_reg[0]  <= esi_reg;
            rsh_reg     <= 45'((mq >> shift_of(mq)) << GUARD_BITS);
            for (int i = 1; i < NV + 3; i++)
            begin
                rm_reg[i]   <= rm_reg[i-1];
                rz_reg[i]   <= rz_reg[i-1];
                rmag_reg[i] <= rmag_reg[i-1];
                rs_reg[i]   <= rs_reg[i-1];
                rph_reg[i]  <= rph_reg[i-1];
                rsr_reg[i]  <= rsr_reg[i-1];
                rsi_reg[i]  <= rsi_reg[i-1];
            end
            rgh_reg <= 45'(rsh_reg[44:30]) * 45'(INV_GAIN);
            rgl_reg <= 60'(rsh_reg[29:0]) * 60'(INV_GAIN);
        end
    end

    logic signed [49:0] x0;
    assign x0 = 50'(rgh_reg) + 50'(rgl_reg >> 30);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (rph_reg[1] > ANG_HALF_PI)
            begin
                rx_reg[0] <= 50'sd0;
                ry_reg[0] <= x0;
                rzz_reg[0] <= rph_reg[1] - ANG_HALF_PI;
            end
            else if (rph_reg[1] < -ANG_HALF_PI)
            begin
                rx_reg[0] <= 50'sd0;
                ry_reg[0] <= -x0;
                rzz_reg[0] <= rph_reg[1] + ANG_HALF_PI;
            end
            else
            begin
                rx_reg[0] <= x0;
                ry_reg[0] <= 50'sd0;
                rzz_reg[0] <= rph_reg[1];
            end
        end
    end

    for (genvar i = 0; i < NV; i++)
    begin : g_rot
        logic signed [49:0] dx, dy;
        assign dx = ry_reg[i] >>> i;
        assign dy = rx_reg[i] >>> i;
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                if (rzz_reg[i] >= 36'sd0)
                begin
                    rx_reg[i+1]  <= rx_reg[i] - dx;
                    ry_reg[i+1]  <= ry_reg[i] + dy;
                    rzz_reg[i+1] <= rzz_reg[i] - atan_q30(5'(i));
                end
                else
                begin
                    rx_reg[i+1]  <= rx_reg[i] + dx;
                    ry_reg[i+1]  <= ry_reg[i] - dy;
                    rzz_reg[i+1] <= rzz_reg[i] + atan_q30(5'(i));
                end
            end
        end
    end

    // Output stage.
    function automatic logic signed [32:0] back(input logic signed [49:0] v,
                                                input logic [5:0] s);
        logic signed [49:0] r;
        logic signed [63:0] w;
        r = (v + 50'sd8) >>> GUARD_BITS;
        w = 64'(r) <<< s;
        if (s != 6'd0 && (r > (64'sd2147483647 >>> s)))
            return {1'b1, 32'sh7FFFFFFF};
        if (s != 6'd0 && (64'(r) < -(64'sd1 <<< (31 - s))))
            return {1'b1, 32'sh80000000};
        if (w > 64'sd2147483647)
            return {1'b1, 32'sh7FFFFFFF};
        if (w < -64'sd2147483648)
            return {1'b1, 32'sh80000000};
        return {1'b0, w[31:0]};
    endfunction

    function automatic logic signed [32:0] sat(input logic signed [33:0] v);
        if (v > 34'sd2147483647)
            return {1'b1, 32'sh7FFFFFFF};
        if (v < -34'sd2147483648)
            return {1'b1, 32'sh80000000};
        return {1'b0, v[31:0]};
    endfunction

    localparam int L = NV + 2;
    logic signed [32:0] ore, oim;
    logic [31:0] omag;
    logic        omov;
    logic signed [35:0] ophr;
    logic signed [18:0] oph;

    always_comb
    begin
        if (rm_reg[L] == MODE_ADD)
        begin
            ore = sat(rsr_reg[L]);
            oim = sat(rsi_reg[L]);
        end
        else
        begin
            ore = back(rx_reg[NV], rs_reg[L]);
            oim = back(ry_reg[NV], rs_reg[L]);
        end
        omov = rmag_reg[L] > 67'h7FFFFFFF;
        omag = omov ? 32'h7FFFFFFF : rmag_reg[L][31:0];
        ophr = (rph_reg[L] + (36'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);
        oph  = ophr[18:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tvalid <= 1'b0;
        end
        else if (adv)
        begin
            m_axis_tvalid <= rv_reg[L];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (rz_reg[L] && rm_reg[L] != MODE_ADD && rm_reg[L] != MODE_MUL)
            begin
                m_axis_tdata <= 120'd0;
                m_axis_tuser <= ST_DIVZ;
            end
            else
            begin
                m_axis_tdata <= {6'd0, oph, omag[30:0], oim[31:0], ore[31:0]};
                m_axis_tuser <= (ore[32] || oim[32] || omov) ? ST_OVF : ST_OK;
            end
        end
    end

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("bad status");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_divz: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_DIVZ) |-> m_axis_tdata == 120'd0)
        else $error("nonzero divide-by-zero result");

endmodule

@@ tb/sv/complex_impedance_alu_core_tb.sv @@
`timescale 1ns / 1ps

module complex_impedance_alu_core_tb;
    import cia_pkg::*;

    localparam int FRAC       = 16;
    localparam int STEPS      = 18;
    localparam int LIMIT      = 200000;
    localparam int N_RANDOM   = 2000;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint unsigned RECIP_GAIN = 64'd652032874;

    typedef struct packed {
        logic [1:0]         mode;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } operands_t;

    typedef struct packed {
        logic signed [31:0] re;
        logic signed [31:0] im;
        logic [30:0]        mag;
        logic [18:0]        phase;
        logic [1:0]         status;
    } outcome_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata = '0;   // a_re, a_im, b_re, b_im
    logic [1:0]   s_axis_tuser = '0;   // mode
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [119:0] m_axis_tdata;        // res_re, res_im, res_mag, res_phase
    logic [1:0]   m_axis_tuser;        // status

    operands_t pending_ops[$];
    outcome_t  expected_outcomes[$];
    logic      sent_fire = 1'b0;
    int        n_sent = 0;
    int        n_checked = 0;
    int        n_errors = 0;
    int        cycles = 0;
    int        mode_seen[4] = '{0, 0, 0, 0};
    int        n_divz = 0;
    int        n_ovf = 0;

    longint atan_tab[30] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
        131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
        127, 63, 31, 15, 8, 4, 2
    };

    complex_impedance_alu_core dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic longint unsigned scale_by_gain(input longint unsigned v);
        return (v >> 30) * RECIP_GAIN + (((v & 64'h3FFF_FFFF) * RECIP_GAIN) >> 30);
    endfunction

    function automatic longint wrap_phase(input longint a);
        longint t;
        t = a;
        while (t > PI_Q30) t = t - TWO_PI_Q30;
        while (t <= -PI_Q30) t = t + TWO_PI_Q30;
        return t;
    endfunction

    function automatic longint clamp32(input longint v, inout bit ovf);
        if (v > 64'sd2147483647)
        begin
            ovf = 1'b1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648)
        begin
            ovf = 1'b1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic void to_polar(input longint x, input longint y,
                                     output longint unsigned mag, output longint ang);
        longint xr, yr, z, t, dx, dy;
        z = 0;
        if (y == 0)
        begin
            mag = (x < 0) ? -x : x;
            ang = (x < 0) ? PI_Q30 : 0;
            return;
        end
        if (x == 0)
        begin
            mag = (y < 0) ? -y : y;
            ang = (y > 0) ? HALF_PI_Q30 : -HALF_PI_Q30;
            return;
        end
        xr = x * 16;
        yr = y * 16;
        if (xr < 0)
        begin
            if (yr > 0)
            begin
                t = xr;
                xr = yr;
                yr = -t;
                z = HALF_PI_Q30;
            end
            else
            begin
                t = xr;
                xr = -yr;
                yr = t;
                z = -HALF_PI_Q30;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (yr > 0)
            begin
                xr = xr + dx;
                yr = yr - dy;
                z = z + atan_tab[i];
            end
            else
            begin
                xr = xr - dx;
                yr = yr + dy;
                z = z - atan_tab[i];
            end
        end
        if (xr < 0) xr = 0;
        mag = (scale_by_gain(xr) + 8) >> 4;
        ang = wrap_phase(z);
    endfunction

    function automatic longint widen_back(input longint v, input int s, inout bit ovf);
        if (s > 0)
        begin
            if (v > (64'sd2147483647 >>> s))
            begin
                ovf = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -(64'sd1 <<< (31 - s)))
            begin
                ovf = 1'b1;
                return -64'sd2147483648;
            end
            v = v * (64'sd1 <<< s);
        end
        return clamp32(v, ovf);
    endfunction

    function automatic void to_rect(input longint unsigned m, input longint a,
                                    output longint re, output longint im, inout bit ovf);
        int s;
        longint xr, yr, z, x0, dx, dy;
        s = 0;
        while (s < 40 && (m >> s) >= (64'd1 << 40)) s++;
        x0 = scale_by_gain((m >> s) << 4);
        if (a > HALF_PI_Q30)
        begin
            xr = 0;
            yr = x0;
            z = a - HALF_PI_Q30;
        end
        else if (a < -HALF_PI_Q30)
        begin
            xr = 0;
            yr = -x0;
            z = a + HALF_PI_Q30;
        end
        else
        begin
            xr = x0;
            yr = 0;
            z = a;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = yr >>> i;
            dy = xr >>> i;
            if (z >= 0)
            begin
                xr = xr - dx;
                yr = yr + dy;
                z = z - atan_tab[i];
            end
            else
            begin
                xr = xr + dx;
                yr = yr - dy;
                z = z + atan_tab[i];
            end
        end
        xr = (xr + 8) >>> 4;
        yr = (yr + 8) >>> 4;
        re = widen_back(xr, s, ovf);
        im = widen_back(yr, s, ovf);
    endfunction

    function automatic outcome_t impedance_result(input operands_t op);
        longint ar, ai, br, bi, sr, si, pa, pb, ps, ph, re, im, ph_out;
        longint unsigned ma, mb, ms, m;
        bit ovf;
        outcome_t r;
        ar = op.a_re;
        ai = op.a_im;
        br = op.b_re;
        bi = op.b_im;
        m = 0;
        ph = 0;
        re = 0;
        im = 0;
        ovf = 1'b0;
        r = '0;
        if (op.mode == MODE_ADD)
        begin
            sr = ar + br;
            si = ai + bi;
            to_polar(sr, si, m, ph);
            re = clamp32(sr, ovf);
            im = clamp32(si, ovf);
        end
        else
        begin
            to_polar(ar, ai, ma, pa);
            to_polar(br, bi, mb, pb);
            if (op.mode == MODE_PAR)
            begin
                to_polar(ar + br, ai + bi, ms, ps);
                if (ms == 0)
                begin
                    r.status = ST_DIVZ;
                    return r;
                end
                m = (ma * mb + ms / 2) / ms;
                ph = wrap_phase(wrap_phase(pa + pb) - ps);
            end
            else if (op.mode == MODE_MUL)
            begin
                m = (ma * mb + (64'd1 << (FRAC - 1))) >> FRAC;
                ph = wrap_phase(pa + pb);
            end
            else
            begin
                if (mb == 0)
                begin
                    r.status = ST_DIVZ;
                    return r;
                end
                m = ((ma << FRAC) + mb / 2) / mb;
                ph = wrap_phase(pa - pb);
            end
            if (m == 0) ph = 0;
            to_rect(m, ph, re, im, ovf);
        end
        if (m == 0) ph = 0;
        if (m > 64'h7FFF_FFFF)
        begin
            m = 64'h7FFF_FFFF;
            ovf = 1'b1;
        end
        ph_out = (ph + (64'sd1 <<< (29 - FRAC))) >>> (30 - FRAC);
        r.re = re[31:0];
        r.im = im[31:0];
        r.mag = m[30:0];
        r.phase = ph_out[18:0];
        r.status = ovf ? ST_OVF : ST_OK;
        return r;
    endfunction

    task automatic report(input string field, input logic [31:0] got, input logic [31:0] want);
        $display("mismatch at result %0d: %s got %h expected %h", n_checked, field, got, want);
        n_errors++;
    endtask

    function automatic logic [31:0] pick_value();
        int k;
        k = $urandom_range(0, 99);
        if (k < 45) return $urandom;
        if (k < 70) return 32'($signed($urandom_range(0, 400000)) - 200000);
        if (k < 80) return '0;
        if (k < 85) return 32'h7FFF_FFFF;
        if (k < 90) return 32'h8000_0000;
        return 32'($signed($urandom_range(0, 8)) - 4);
    endfunction

    function automatic operands_t random_ops();
        operands_t op;
        int k;
        op.mode = 2'($urandom_range(0, 3));
        op.a_re = pick_value();
        op.a_im = pick_value();
        op.b_re = pick_value();
        op.b_im = pick_value();
        k = $urandom_range(0, 19);
        if (k == 0)
        begin
            op.b_re = -op.a_re;
            op.b_im = -op.a_im;
        end
        else if (k == 1)
        begin
            op.b_re = '0;
            op.b_im = '0;
        end
        return op;
    endfunction

    function automatic operands_t ops(input logic [1:0] md, input logic [31:0] w,
                                      input logic [31:0] x, input logic [31:0] y,
                                      input logic [31:0] z);
        operands_t op;
        op.mode = md;
        op.a_re = w;
        op.a_im = x;
        op.b_re = y;
        op.b_im = z;
        return op;
    endfunction

    // Driver: a new transfer is offered only once the previous one was taken.
    always @(negedge clk)
    begin
        if (rst_n && (!s_axis_tvalid || sent_fire))
        begin
            if (pending_ops.size() > 0 &&
                ((n_sent >= 800 && n_sent < 1100) || $urandom_range(0, 99) >= 28))
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {pending_ops[0].b_im, pending_ops[0].b_re,
                                  pending_ops[0].a_im, pending_ops[0].a_re};
                s_axis_tuser  <= pending_ops[0].mode;
                void'(pending_ops.pop_front());
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
            end
        end
        if (rst_n)
        begin
            m_axis_tready <= (n_sent >= 800 && n_sent < 1100) || $urandom_range(0, 99) >= 28;
        end
    end

    always @(posedge clk)
    begin
        operands_t op;
        outcome_t want, got;
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("complex_impedance_alu_core_tb: errors");
            $finish;
        end
        sent_fire <= s_axis_tvalid && s_axis_tready;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            op.mode = s_axis_tuser;
            {op.b_im, op.b_re, op.a_im, op.a_re} = s_axis_tdata;
            want = impedance_result(op);
            expected_outcomes.push_back(want);
            mode_seen[op.mode]++;
            if (want.status == ST_DIVZ) n_divz++;
            if (want.status == ST_OVF) n_ovf++;
            n_sent++;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.re = m_axis_tdata[31:0];
            got.im = m_axis_tdata[63:32];
            got.mag = m_axis_tdata[94:64];
            got.phase = m_axis_tdata[113:95];
            got.status = m_axis_tuser;
            if (expected_outcomes.size() == 0)
            begin
                $display("unexpected transfer on the result side");
                n_errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                if (got.re !== want.re) report("res_re", got.re, want.re);
                if (got.im !== want.im) report("res_im", got.im, want.im);
                if (got.mag !== want.mag) report("res_mag", got.mag, want.mag);
                if (got.phase !== want.phase) report("res_phase", got.phase, want.phase);
                if (got.status !== want.status) report("status", got.status, want.status);
            end
            n_checked++;
        end
    end

    initial
    begin
        logic [31:0] mx, mn;
        mx = 32'h7FFF_FFFF;
        mn = 32'h8000_0000;
        for (int md = 0; md < 4; md++)
        begin
            pending_ops.push_back(ops(2'(md), mx, mx, mx, mx));
            pending_ops.push_back(ops(2'(md), mn, mn, mn, mn));
            pending_ops.push_back(ops(2'(md), 32'h0001_0000, 0, 0, 32'h0002_0000));
            pending_ops.push_back(ops(2'(md), mn, 0, 0, mn));
        end
        pending_ops.push_back(ops(MODE_DIV, 32'h0003_0000, 32'h0004_0000, 0, 0));
        pending_ops.push_back(ops(MODE_PAR, 32'h0001_0000, mn, 32'hFFFF_0000, mx + 1));
        pending_ops.push_back(ops(MODE_ADD, 0, 0, 0, 0));
        pending_ops.push_back(ops(MODE_MUL, 1, 0, 0, 1));
        pending_ops.push_back(ops(MODE_DIV, 1, 1, mx, mx));
        pending_ops.push_back(ops(MODE_DIV, mx, mn, 1, 0));
        pending_ops.push_back(ops(MODE_MUL, 32'hFFFF_0000, 1, 32'hFFFF_0000, 32'hFFFF_FFFF));
        pending_ops.push_back(ops(MODE_PAR, 32'h0002_0000, 32'h0002_0000, mn, mx));
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_outcomes.size() == 0);
        for (int n = 0; n < N_RANDOM; n++) pending_ops.push_back(random_ops());
        wait (pending_ops.size() == 0 && !s_axis_tvalid && expected_outcomes.size() == 0);
        repeat (60) @(posedge clk);
        $display("%0d transfers checked: add %0d, parallel %0d, multiply %0d, divide %0d",
                 n_checked, mode_seen[0], mode_seen[1], mode_seen[2], mode_seen[3]);
        $display("zero-divisor results %0d, saturated results %0d", n_divz, n_ovf);
        if (n_errors == 0)
            $display("complex_impedance_alu_core_tb: clean");
        else
            $display("complex_impedance_alu_core_tb: errors");
        $finish;
    end

endmodule
